[rtl/core/grc_pkg.sv]
package grc_pkg;

  // Fixed-point format shared by every coordinate and length
  localparam int FRAC_BITS = 16;

  // Default geometry
  localparam int DEF_MAP_DIM  = 64;
  localparam int DEF_SCREEN_W = 640;
  localparam int DEF_SCREEN_H = 480;
  localparam int DEF_TEX_W    = 64;

  // Register and datapath widths
  localparam int POS_W     = 22;
  localparam int VEC_W     = 18;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CAM_W     = 25;
  localparam int RAY_W     = 28;
  localparam int DELTA_W   = 49;
  localparam int SIDE_W    = 58;
  localparam int CELL_W    = 10;
  localparam int DIFF_W    = 27;
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 28;
  localparam int DIV_CNT_W = 6;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PLANE_Y = 3'd5;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_wall;
    logic [9:0] screen_column;
  } cast_item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        wall_axis;
    logic        ray_x_negative;
    logic        ray_y_negative;
    logic [5:0]  hit_cell_x;
    logic [5:0]  hit_cell_y;
    logic [23:0] wall_distance;
    logic [5:0]  texture_column;
    logic [8:0]  span_top;
    logic [8:0]  span_bottom;
    logic        escaped;
  } result_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_RAY_MUL,
    ST_RAY_ADD,
    ST_DX_LOAD,
    ST_DX_DIV,
    ST_DY_DIV,
    ST_SIDE_INIT,
    ST_STEP,
    ST_PROBE,
    ST_HIT_PREP,
    ST_Q_LOAD,
    ST_Q_DIV,
    ST_T_DIV,
    ST_WALL,
    ST_TEX,
    ST_H_DIV,
    ST_FINISH
  } grc_state_t;

endpackage

[rtl/core/grid_ray_caster_column_top.sv]
// Write item: taken while idle, no result.
// Cast item: five divisions on the shared bit-serial divider and one map read per cell
// stepped (at most 2*MAP_DIM+4 cells), fewer divisions when the ray escapes; one item at
// a time, as the divider and the map memory are shared.
// Reset: configuration registers take their defaults and the map is swept clear, all
// MAP_DIM*MAP_DIM cells (4096 by default), with the input stalled.
module grid_ray_caster_column_top import grc_pkg::*; #(
  parameter int MAP_DIM  = DEF_MAP_DIM,
  parameter int SCREEN_W = DEF_SCREEN_W,
  parameter int SCREEN_H = DEF_SCREEN_H,
  parameter int TEX_W    = DEF_TEX_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cast_valid,
  output logic                 cast_stall,
  input  cast_item_t           cast_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_item_t         result_item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH      = MAP_DIM * MAP_DIM;
  localparam int AW         = $clog2(DEPTH);
  localparam int STEP_LIMIT = 2 * MAP_DIM + 4;
  localparam int STEP_CW    = $clog2(STEP_LIMIT + 1);
  localparam logic signed [CELL_W-1:0] MAP_LIM = CELL_W'(MAP_DIM);
  localparam logic [10:0] TEX_W_C   = 11'(TEX_W);
  localparam logic [12:0] SH_FULL   = 13'(SCREEN_H - 1);
  localparam logic [12:0] SH_HALF   = 13'(SCREEN_H / 2);
  localparam logic [DIV_NUM_W-1:0] SH_NUM  = DIV_NUM_W'(SCREEN_H) << FRAC_BITS;
  localparam logic [DIV_NUM_W-1:0] SH_VAL  = DIV_NUM_W'(SCREEN_H);
  localparam logic [DIV_NUM_W-1:0] ONE_SQ  = DIV_NUM_W'(1) << (2 * FRAC_BITS);
  localparam logic [DELTA_W-1:0]   D_CAP   = DELTA_W'(1) << 48;
  localparam logic [23:0]          WD_MAX  = 24'hFFFFFF;
  // Reciprocal of the screen width, rounded up, scaled by 2^39
  localparam logic [35:0] CAM_RECIP =
    36'(((64'd1 << 39) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  // Configuration registers
  logic        [POS_W-1:0] player_x, player_y;
  logic signed [VEC_W-1:0] view_dir_x, view_dir_y, camera_plane_x, camera_plane_y;

  // Sequencer
  grc_state_t state, state_next;

  // Datapath registers
  logic        [9:0]           col;
  logic signed [CAM_W-1:0]     cam;
  logic signed [42:0]          prod_x, prod_y;
  logic signed [RAY_W-1:0]     rx, ry;
  logic        [DELTA_W-1:0]   dx, dy;
  logic        [SIDE_W-1:0]    sx, sy;
  logic signed [CELL_W-1:0]    cx, cy;
  logic                        side, hit;
  logic        [STEP_CW-1:0]   step_cnt;
  logic        [25:0]          diff_mag;
  logic        [DIV_DEN_W-1:0] den_mag, oth_mag;
  logic                        neg, den_zero;
  logic        [15:0]          base_frac;
  logic        [53:0]          prod_t;
  logic        [41:0]          q;
  logic        [15:0]          t_low;
  logic        [23:0]          wd;
  logic        [15:0]          wall_frac;
  logic        [10:0]          tex;
  logic        [12:0]          ds, de;
  logic        [AW-1:0]        clr_addr;

  // Divider registers
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den, div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Control
  logic                 accept, div_load, div_done, out_free;
  logic [DIV_NUM_W-1:0] div_num_in;
  logic [DIV_DEN_W-1:0] div_den_in;
  logic                 ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]        ram_waddr, ram_raddr;

  // Step and hit logic
  logic                     go_x, leave, limit_hit, mirror;
  logic signed [CELL_W-1:0] nx, ny;
  logic        [RAY_W-1:0]  rx_mag, ry_mag;
  logic        [16:0]       fx, fy;
  logic        [49:0]       mx, my;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [CELL_W-1:0] cell_sel;
  logic        [POS_W-1:0]  pos_sel;
  logic                     step_neg, wr_in_map;
  logic        [26:0]       tex_prod;
  logic        [10:0]       tex_raw;
  logic        [DIV_DEN_W:0] div_trial;
  logic        [45:0]       cam_prod;

  assign accept   = cast_valid && !cast_stall;
  assign div_done = (div_cnt == '0);
  assign out_free = !result_valid || !result_stall;

  assign rx_mag = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
  assign ry_mag = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);

  // Camera offset: 2*column/SCREEN_W - 1 in fixed point, by reciprocal multiplication
  assign cam_prod = 46'(col) * 46'(CAM_RECIP);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x       <= 22'd131072;
      player_y       <= 22'd131072;
      view_dir_x     <= 18'sd65536;
      view_dir_y     <= 18'sd0;
      camera_plane_x <= 18'sd0;
      camera_plane_y <= 18'sd43253;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PLAYER_X:       player_x       <= cfg_data;
        CFG_PLAYER_Y:       player_y       <= cfg_data;
        CFG_VIEW_DIR_X:     view_dir_x     <= signed'(cfg_data[VEC_W-1:0]);
        CFG_VIEW_DIR_Y:     view_dir_y     <= signed'(cfg_data[VEC_W-1:0]);
        CFG_CAMERA_PLANE_X: camera_plane_x <= signed'(cfg_data[VEC_W-1:0]);
        CFG_CAMERA_PLANE_Y: camera_plane_y <= signed'(cfg_data[VEC_W-1:0]);
        default: ;
      endcase
    end
  end

  // Take one step along the nearer grid line
  always_comb begin
    go_x      = sx < sy;
    nx        = cx;
    ny        = cy;
    if (go_x) begin
      nx = rx[RAY_W-1] ? cx - CELL_W'(1) : cx + CELL_W'(1);
    end else begin
      ny = ry[RAY_W-1] ? cy - CELL_W'(1) : cy + CELL_W'(1);
    end
    leave     = (nx < 0) || (nx >= MAP_LIM) || (ny < 0) || (ny >= MAP_LIM);
    limit_hit = (step_cnt == STEP_CW'(STEP_LIMIT));
  end

  // Side distances to the first grid lines
  always_comb begin
    fx = rx[RAY_W-1] ? {1'b0, player_x[15:0]} : 17'h10000 - {1'b0, player_x[15:0]};
    fy = ry[RAY_W-1] ? {1'b0, player_y[15:0]} : 17'h10000 - {1'b0, player_y[15:0]};
    mx = fx * dx[32:0];
    my = fy * dy[32:0];
  end

  // Distance from the player to the wall face that was hit
  always_comb begin
    cell_sel = side ? cy : cx;
    pos_sel  = side ? player_y : player_x;
    step_neg = side ? ry[RAY_W-1] : rx[RAY_W-1];
    diff_w   = DIFF_W'(signed'({cell_sel, 16'h0})) - DIFF_W'(signed'({1'b0, pos_sel}))
             + (step_neg ? DIFF_W'(65536) : DIFF_W'(0));
  end

  // Texture column and its mirroring
  always_comb begin
    tex_prod = wall_frac * TEX_W_C;
    tex_raw  = tex_prod[26:16];
    mirror   = (side && !ry[RAY_W-1] && (ry != '0)) || (!side && rx[RAY_W-1]);
  end

  assign wr_in_map = (10'(cast_item.cell_x) < 10'(MAP_DIM))
                  && (10'(cast_item.cell_y) < 10'(MAP_DIM));

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (accept && cast_item.mode == MODE_CAST) state_next = ST_CAM;
      ST_CAM:       state_next = ST_RAY_MUL;
      ST_RAY_MUL:   state_next = ST_RAY_ADD;
      ST_RAY_ADD:   state_next = ST_DX_LOAD;
      ST_DX_LOAD:   state_next = ST_DX_DIV;
      ST_DX_DIV:    if (div_done) state_next = ST_DY_DIV;
      ST_DY_DIV:    if (div_done) state_next = ST_SIDE_INIT;
      ST_SIDE_INIT: state_next = ST_STEP;
      ST_STEP:      state_next = (limit_hit || leave) ? ST_FINISH : ST_PROBE;
      ST_PROBE:     state_next = ram_rdata ? ST_HIT_PREP : ST_STEP;
      ST_HIT_PREP:  state_next = ST_Q_LOAD;
      ST_Q_LOAD:    state_next = ST_Q_DIV;
      ST_Q_DIV:     if (div_done) state_next = ST_T_DIV;
      ST_T_DIV:     if (div_done) state_next = ST_WALL;
      ST_WALL:      state_next = ST_TEX;
      ST_TEX:       state_next = ST_H_DIV;
      ST_H_DIV:     if (div_done) state_next = ST_FINISH;
      ST_FINISH:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Control outputs: stall, divider loads, memory ports
  always_comb begin
    cast_stall = (state != ST_IDLE);
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(32'(cast_item.cell_y) * 32'(MAP_DIM) + 32'(cast_item.cell_x));
    ram_wdata  = cast_item.cell_wall;
    ram_raddr  = AW'(32'(unsigned'(ny)) * 32'(MAP_DIM) + 32'(unsigned'(nx)));
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b0;
      end
      ST_IDLE: begin
        if (accept && cast_item.mode == MODE_WRITE) begin
          ram_we = wr_in_map;
        end
      end
      ST_DX_LOAD: begin
        div_load   = 1'b1;
        div_num_in = ONE_SQ;
        div_den_in = rx_mag;
      end
      ST_DX_DIV: begin
        if (div_done) begin
          div_load   = 1'b1;
          div_num_in = ONE_SQ;
          div_den_in = ry_mag;
        end
      end
      ST_Q_LOAD: begin
        div_load   = 1'b1;
        div_num_in = DIV_NUM_W'({diff_mag, 16'h0});
        div_den_in = den_mag;
      end
      ST_Q_DIV: begin
        if (div_done) begin
          div_load   = 1'b1;
          div_num_in = DIV_NUM_W'(prod_t);
          div_den_in = den_mag;
        end
      end
      ST_TEX: begin
        div_load   = 1'b1;
        div_num_in = SH_NUM;
        div_den_in = DIV_DEN_W'(wd);
      end
      default: ;
    endcase
  end

  // Shared restoring divider, one quotient bit a cycle
  assign div_trial = {div_rem, div_num[DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_cnt <= DIV_CNT_W'(DIV_NUM_W);
    end else if (!div_done) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_num <= div_num_in;
      div_den <= div_den_in;
      div_rem <= '0;
    end else if (!div_done) begin
      if (div_trial >= {1'b0, div_den}) begin
        div_rem <= DIV_DEN_W'(div_trial - {1'b0, div_den});
        div_num <= {div_num[DIV_NUM_W-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[DIV_DEN_W-1:0];
        div_num <= {div_num[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  // Sweep counter for the map clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col <= cast_item.screen_column;
        cx  <= CELL_W'(signed'({1'b0, player_x[POS_W-1:FRAC_BITS]}));
        cy  <= CELL_W'(signed'({1'b0, player_y[POS_W-1:FRAC_BITS]}));
        hit <= 1'b0;
      end
      ST_CAM: begin
        cam <= CAM_W'(signed'({1'b0, cam_prod[45:22]})) - CAM_W'(65536);
      end
      ST_RAY_MUL: begin
        prod_x <= 43'(camera_plane_x) * 43'(cam);
        prod_y <= 43'(camera_plane_y) * 43'(cam);
      end
      ST_RAY_ADD: begin
        rx <= RAY_W'(view_dir_x) + RAY_W'(signed'(prod_x[42:16]));
        ry <= RAY_W'(view_dir_y) + RAY_W'(signed'(prod_y[42:16]));
      end
      ST_DX_DIV: begin
        if (div_done) begin
          dx <= (rx == '0) ? D_CAP : DELTA_W'(div_num[32:0]);
        end
      end
      ST_DY_DIV: begin
        if (div_done) begin
          dy <= (ry == '0) ? D_CAP : DELTA_W'(div_num[32:0]);
        end
      end
      ST_SIDE_INIT: begin
        sx       <= (rx == '0) ? SIDE_W'(fx) << 32 : SIDE_W'(mx[49:16]);
        sy       <= (ry == '0) ? SIDE_W'(fy) << 32 : SIDE_W'(my[49:16]);
        step_cnt <= '0;
      end
      ST_STEP: begin
        if (!limit_hit) begin
          step_cnt <= step_cnt + STEP_CW'(1);
          cx       <= nx;
          cy       <= ny;
          side     <= !go_x;
          if (go_x) begin
            sx <= sx + SIDE_W'(dx);
          end else begin
            sy <= sy + SIDE_W'(dy);
          end
        end
      end
      ST_PROBE: begin
        hit <= ram_rdata;
      end
      ST_HIT_PREP: begin
        diff_mag  <= diff_w[DIFF_W-1] ? 26'(-diff_w) : 26'(diff_w);
        den_mag   <= side ? ry_mag : rx_mag;
        oth_mag   <= side ? rx_mag : ry_mag;
        den_zero  <= side ? (ry == '0) : (rx == '0);
        neg       <= diff_w[DIFF_W-1] ^ ry[RAY_W-1] ^ rx[RAY_W-1];
        base_frac <= side ? player_x[15:0] : player_y[15:0];
      end
      ST_Q_LOAD: begin
        prod_t <= diff_mag * oth_mag;
      end
      ST_Q_DIV: begin
        if (div_done) begin
          q <= div_num[41:0];
        end
      end
      ST_T_DIV: begin
        if (div_done) begin
          t_low <= div_num[15:0];
        end
      end
      ST_WALL: begin
        wd        <= den_zero ? WD_MAX : ((q > 42'(WD_MAX)) ? WD_MAX : q[23:0]);
        wall_frac <= den_zero ? base_frac
                   : base_frac + (neg ? 16'(-t_low) : t_low);
      end
      ST_TEX: begin
        tex <= mirror ? TEX_W_C - 11'd1 - tex_raw : tex_raw;
      end
      ST_H_DIV: begin
        if (div_done) begin
          if ((wd == '0) || (div_num > SH_VAL)) begin
            ds <= '0;
            de <= SH_FULL;
          end else begin
            ds <= SH_HALF - (div_num[12:0] >> 1);
            de <= SH_HALF + (div_num[12:0] >> 1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      result_item.column_out     <= col;
      result_item.wall_axis      <= hit & side;
      result_item.ray_x_negative <= rx[RAY_W-1];
      result_item.ray_y_negative <= ry[RAY_W-1];
      result_item.hit_cell_x     <= hit ? cx[5:0] : 6'd0;
      result_item.hit_cell_y     <= hit ? cy[5:0] : 6'd0;
      result_item.wall_distance  <= hit ? wd : 24'd0;
      result_item.texture_column <= hit ? tex[5:0] : 6'd0;
      result_item.span_top       <= hit ? ds[8:0] : 9'd0;
      result_item.span_bottom    <= hit ? de[8:0] : 9'd0;
      result_item.escaped        <= !hit;
    end
  end

  grc_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

[rtl/core/grc_ram.sv]
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[bench/tb.sv]
module tb;
  import grc_pkg::*;

  localparam int MAP_N  = 64;
  localparam int SCR_W  = 640;
  localparam int SCR_H  = 480;
  localparam int TEXW   = 64;
  localparam longint ONE_FX = 64'd65536;
  localparam longint CAP_FX = 64'h1_0000_0000_0000;
  localparam int WATCH_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cast_valid = 1'b0;
  logic cast_stall;
  cast_item_t cast_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_item_t result_item;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  grid_ray_caster_column_top dut (
    .clk(clk), .rst(rst),
    .cast_valid(cast_valid), .cast_stall(cast_stall), .cast_item(cast_item),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_item(result_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block state
  bit wall_map [MAP_N*MAP_N];
  longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;

  cast_item_t pending_items[$];
  result_item_t expected_columns[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  initial forever #5 clk = ~clk;

  function automatic longint floor_shift(longint v);
    if (v >= 0) return v >>> 16;
    return -(((-v) - 1) >>> 16) - 1;
  endfunction

  function automatic longint abs_val(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint step_length(longint r);
    longint a, d;
    a = abs_val(r);
    if (a == 0) return CAP_FX;
    d = (ONE_FX * ONE_FX) / a;
    return d > CAP_FX ? CAP_FX : d;
  endfunction

  function automatic longint scale_fx(longint f, longint d);
    return (d >> 16) * f + (((d & (ONE_FX - 1)) * f) >> 16);
  endfunction

  // Apply one item to the shadow state; return the column result of a cast
  function automatic bit cast_column(cast_item_t it, output result_item_t r);
    longint cam, rx, ry, cx, cy, stx, sty, sx, sy, dx, dy;
    longint wd, tex, ds, de, diff, den, oth, base, wall, q, t, h;
    int side, hit;
    bit neg;
    r = '0;
    wd = 0; tex = 0; ds = 0; de = 0; side = 0; hit = 0;
    if (it.mode == MODE_WRITE) begin
      wall_map[it.cell_y * MAP_N + it.cell_x] = it.cell_wall;
      return 1'b0;
    end
    cam = ((2 * longint'(it.screen_column)) << 16) / SCR_W - ONE_FX;
    rx = dir_x + floor_shift(plane_x * cam);
    ry = dir_y + floor_shift(plane_y * cam);
    cx = pos_x >>> 16;
    cy = pos_y >>> 16;
    dx = step_length(rx);
    dy = step_length(ry);
    if (rx >= 0) begin
      stx = 1; sx = scale_fx((cx + 1) * ONE_FX - pos_x, dx);
    end else begin
      stx = -1; sx = scale_fx(pos_x - cx * ONE_FX, dx);
    end
    if (ry >= 0) begin
      sty = 1; sy = scale_fx((cy + 1) * ONE_FX - pos_y, dy);
    end else begin
      sty = -1; sy = scale_fx(pos_y - cy * ONE_FX, dy);
    end
    // Walk the grid; a tie steps along y
    for (int n = 0; n < 2 * MAP_N + 4; n++) begin
      if (sx < sy) begin
        sx += dx; cx += stx; side = 0;
      end else begin
        sy += dy; cy += sty; side = 1;
      end
      if (cx < 0 || cx >= MAP_N || cy < 0 || cy >= MAP_N) break;
      if (wall_map[cy * MAP_N + cx]) begin
        hit = 1;
        break;
      end
    end
    if (hit) begin
      if (side == 0) begin
        diff = cx * ONE_FX - pos_x + (stx < 0 ? ONE_FX : 0);
        den = rx; oth = ry; base = pos_y;
      end else begin
        diff = cy * ONE_FX - pos_y + (sty < 0 ? ONE_FX : 0);
        den = ry; oth = rx; base = pos_x;
      end
      if (den == 0) begin
        wd = 64'hFFFFFF; wall = base;
      end else begin
        q = (abs_val(diff) * ONE_FX) / abs_val(den);
        t = (abs_val(diff) * abs_val(oth)) / abs_val(den);
        neg = ((diff < 0) != (oth < 0)) != (den < 0);
        wd = q > 64'hFFFFFF ? 64'hFFFFFF : q;
        wall = base + (neg ? -t : t);
      end
      tex = ((wall & (ONE_FX - 1)) * TEXW) >> 16;
      if ((side == 1 && ry > 0) || (side == 0 && rx < 0)) tex = TEXW - 1 - tex;
      h = (wd == 0) ? SCR_H + 1 : (longint'(SCR_H) << 16) / wd;
      if (h > SCR_H) begin
        ds = 0; de = SCR_H - 1;
      end else begin
        ds = SCR_H / 2 - h / 2; de = SCR_H / 2 + h / 2;
      end
    end
    r.column_out     = it.screen_column;
    r.wall_axis      = hit ? side[0] : 1'b0;
    r.ray_x_negative = rx < 0;
    r.ray_y_negative = ry < 0;
    r.hit_cell_x     = hit ? cx[5:0] : 6'd0;
    r.hit_cell_y     = hit ? cy[5:0] : 6'd0;
    r.wall_distance  = wd[23:0];
    r.texture_column = tex[5:0];
    r.span_top       = ds[8:0];
    r.span_bottom    = de[8:0];
    r.escaped        = !hit;
    return 1'b1;
  endfunction

  // Drive items from the pending queue, predicting each on acceptance
  always @(posedge clk) begin
    result_item_t r;
    if (!rst) begin
      if (cast_valid && !cast_stall) begin
        if (cast_column(cast_item, r)) expected_columns.push_back(r);
        void'(pending_items.pop_front());
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
        cast_valid <= 1'b0;
      end else if (!cast_valid && pending_items.size() > 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else begin
          cast_item <= pending_items[0];
          cast_valid <= 1'b1;
        end
      end
    end
  end

  // Check results against the oldest prediction; randomise back-pressure
  always @(posedge clk) begin
    result_item_t e;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_item);
          errors++;
        end else begin
          e = expected_columns.pop_front();
          if (e !== result_item) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result_item);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        result_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else begin
        result_stall <= 1'b0;
        if (result_valid && !result_stall)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (rst || (cast_valid && !cast_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_PLAYER_X:       pos_x = val & 64'h3FFFFF;
      CFG_PLAYER_Y:       pos_y = val & 64'h3FFFFF;
      CFG_VIEW_DIR_X:     dir_x = longint'($signed(val[17:0]));
      CFG_VIEW_DIR_Y:     dir_y = longint'($signed(val[17:0]));
      CFG_CAMERA_PLANE_X: plane_x = longint'($signed(val[17:0]));
      CFG_CAMERA_PLANE_Y: plane_y = longint'($signed(val[17:0]));
      default:            ;
    endcase
  endtask

  task automatic load_view(input longint px, py, vx, vy, cx, cy);
    write_reg(CFG_PLAYER_X, px);
    write_reg(CFG_PLAYER_Y, py);
    write_reg(CFG_VIEW_DIR_X, vx);
    write_reg(CFG_VIEW_DIR_Y, vy);
    write_reg(CFG_CAMERA_PLANE_X, cx);
    write_reg(CFG_CAMERA_PLANE_Y, cy);
  endtask

  // Wait until all queued items are accepted and every result has returned
  task automatic drain();
    while (pending_items.size() > 0 || cast_valid || expected_columns.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cast_item_t cell_write(int x, int y, bit w);
    cast_item_t it;
    it = '0;
    it.mode = MODE_WRITE; it.cell_x = 6'(x); it.cell_y = 6'(y); it.cell_wall = w;
    it.screen_column = 10'($urandom);
    return it;
  endfunction

  function automatic cast_item_t column_cast(int c);
    cast_item_t it;
    it = '0;
    it.cell_x = 6'($urandom); it.cell_y = 6'($urandom); it.cell_wall = 1'($urandom);
    it.mode = MODE_CAST; it.screen_column = 10'(c);
    return it;
  endfunction

  function automatic longint rand_vec();
    case ($urandom_range(0, 5))
      0: return -131072;
      1: return 131071;
      2: return 0;
      3: return longint'($urandom_range(0, 131072)) - 65536;
      default: return longint'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  initial begin
    int col;
    pos_x = 131072; pos_y = 131072; dir_x = 65536; dir_y = 0;
    plane_x = 0; plane_y = 43253;
    foreach (wall_map[i]) wall_map[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty map escapes at reset view, then a walled room
    pending_items.push_back(column_cast(0));
    pending_items.push_back(column_cast(320));
    pending_items.push_back(column_cast(639));
    pending_items.push_back(column_cast(1023));
    for (int i = 0; i < 8; i++) begin
      pending_items.push_back(cell_write(i, 0, 1));
      pending_items.push_back(cell_write(0, i, 1));
      pending_items.push_back(cell_write(7, i, 1));
      pending_items.push_back(cell_write(i, 7, 1));
    end
    pending_items.push_back(cell_write(63, 63, 1));
    pending_items.push_back(cell_write(63, 63, 0));
    pending_items.push_back(column_cast(0));
    pending_items.push_back(column_cast(320));
    pending_items.push_back(column_cast(639));
    drain();

    // Directed views: axis rays with zero plane, diagonal tie, extremes
    load_view(3 * 65536, 3 * 65536, 0, 131071, 0, 0);
    pending_items.push_back(column_cast(100));
    drain();
    load_view(3 * 65536 + 32768, 3 * 65536 + 32768, -131072, -131072, 0, 0);
    pending_items.push_back(column_cast(5));
    drain();
    load_view(65536, 65536, 65536, 65536, 0, 0);
    pending_items.push_back(column_cast(320));
    drain();
    load_view(4194303, 4194303, 131071, -131072, -131072, 131071);
    pending_items.push_back(column_cast(0));
    pending_items.push_back(column_cast(639));
    drain();
    load_view(0, 0, 65536, 0, 0, 43253);
    pending_items.push_back(column_cast(320));
    drain();
    // Player next to a wall cell
    load_view(65536 + 100, 65536 + 100, 65536, 0, 0, 43253);
    pending_items.push_back(cell_write(2, 1, 1));
    pending_items.push_back(column_cast(320));
    drain();

    // Random phases: random map content, views mostly inside the map
    for (int ph = 0; ph < 26; ph++) begin
      load_view((ph % 9 == 0) ? longint'($urandom_range(0, 4194303))
                              : longint'($urandom_range(65536, 63 * 65536)),
                (ph % 9 == 1) ? longint'($urandom_range(0, 4194303))
                              : longint'($urandom_range(65536, 63 * 65536)),
                rand_vec(), rand_vec(), rand_vec(), rand_vec());
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 2) == 0)
          pending_items.push_back(cell_write($urandom_range(0, 63),
                                             $urandom_range(0, 63), $urandom_range(0, 1)));
        else begin
          col = ($urandom_range(0, 9) == 0) ? $urandom_range(640, 1023)
                                            : $urandom_range(0, 639);
          pending_items.push_back(column_cast(col));
        end
      end
      drain();
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[grid_ray_caster_column_top.f]
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/grid_ray_caster_column_top.sv
bench/tb.sv
